@@ hw/rtl/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg: shared types and constants of the deadline timer queue
// widths of the payload fields, request and result codes, alu interface
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int unsigned TIMER_SLOTS_DEFAULT = 16;

   localparam int unsigned TIME_W = 63;
   localparam int unsigned IVL_W  = 40;
   localparam int unsigned ARM_W  = 20;
   localparam int unsigned SLOT_W = 4;

   localparam logic [ARM_W-1:0] MIN_ARM_RESET = ARM_W'(100);

   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      KIND_ADD_OK    = 2'd0,
      KIND_ADD_FULL  = 2'd1,
      KIND_EXPIRED   = 2'd2,
      KIND_TICK_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ALU_LT  = 2'd0,
      ALU_SUB = 2'd1,
      ALU_ADD = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [TIME_W-1:0] res;
      logic              lt;
   } alu_rsp_type;

endpackage

@@ hw/rtl/dtq_chan_if.sv @@
// ----------------------------------------------------------------------------
// dtq channel interfaces
// request and response channels, valid/ready handshake with payload
// ----------------------------------------------------------------------------
interface dtq_req_if import dtq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [TIME_W-1:0] now_time;
   logic [TIME_W-1:0] expiry_time;
   logic [IVL_W-1:0]  interval_us;

   modport source (output valid, req_type, now_time, expiry_time, interval_us,
                   input ready);
   modport sink   (input valid, req_type, now_time, expiry_time, interval_us,
                   output ready);
endinterface

interface dtq_rsp_if import dtq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        result_kind;
   logic [SLOT_W-1:0] timer_slot;
   logic              earliest_changed;
   logic              arm_valid;
   logic [TIME_W-1:0] arm_delay_us;
   logic              last_result;

   modport source (output valid, result_kind, timer_slot, earliest_changed,
                   arm_valid, arm_delay_us, last_result, input ready);
   modport sink   (input valid, result_kind, timer_slot, earliest_changed,
                   arm_valid, arm_delay_us, last_result, output ready);
endinterface

@@ hw/rtl/dtq_alu.sv @@
// ----------------------------------------------------------------------------
// dtq_alu: shared 63-bit arithmetic unit
// one adder serves less-than compare, clamped subtract and saturating add
// ----------------------------------------------------------------------------
module dtq_alu import dtq_pkg::*; (
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   logic          inv;
   logic [TIME_W:0] sum;

   assign inv = (alu_req.op != ALU_ADD);
   assign sum = {1'b0, alu_req.a} + ({1'b0, alu_req.b} ^ {(TIME_W+1){inv}})
                + (TIME_W+1)'(inv);

   always_comb begin
      alu_rsp.lt = inv & sum[TIME_W];
      unique case (alu_req.op)
         ALU_SUB: begin
            // a minus b, zero when b is not below a
            alu_rsp.res = sum[TIME_W] ? '0 : sum[TIME_W-1:0];
         end
         ALU_ADD: begin
            // saturate at the top of the 63-bit range
            alu_rsp.res = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
         end
         default: begin
            alu_rsp.res = sum[TIME_W-1:0];
         end
      endcase
   end

endmodule

@@ hw/rtl/deadline_timer_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_queue: table of timers with sorted expiry
// add stores a timer in the lowest free slot, tick emits expired timers in
// deadline order, reloads repeating ones and reports the next arming delay
// ----------------------------------------------------------------------------
//
//  channel    dir   handshake          word
//  req_chan   in    valid/ready        req_type, now_time, expiry_time,
//                                      interval_us
//  rsp_chan   out   valid/ready        result_kind, timer_slot,
//                                      earliest_changed, arm_valid,
//                                      arm_delay_us, last_result
//  csr_*      in    wr_en strobe       min_arm_delay (20 bits)
//
//  scans: every slot scan walks the deadline memory read port; an add
//  gives one word, whether full or armed, a tick with nothing expired
//  one word, and with E expired timers the last of E words carries
//  last_result and, if a timer is still pending, the arming delay
//  reset: synchronous, clears valid bits, sequencer and output register;
//  no clearing pass, memory words are only read behind a valid bit
//  stalls: a result sits in the output register while the sequencer works
//  on; the sequencer waits only when it has a new result and the register
//  is still full; req ready is high only while idle
// ----------------------------------------------------------------------------
module deadline_timer_queue import dtq_pkg::*; #(
   parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [ARM_W-1:0] csr_wr_data,
   dtq_req_if.sink          req_chan,
   dtq_rsp_if.source        rsp_chan
);

   localparam int unsigned IW = $clog2(TIMER_SLOTS);
   localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
   localparam logic [CW-1:0] SLOT_COUNT = CW'(TIMER_SLOTS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIN_SCAN,
      ST_ADD_CMP,
      ST_HIT_SCAN,
      ST_BEST_SCAN,
      ST_RELOAD,
      ST_ARM_SUB,
      ST_ARM_CLAMP,
      ST_RESULT
   } state_type;

   // sequencer state
   state_type         state_ff, state_in;
   logic              op_tick_ff, op_tick_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              ev_vld_ff, ev_vld_in;
   logic [IW-1:0]     ev_slot_ff, ev_slot_in;

   // captured request word
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] when_ff, when_in;
   logic [IVL_W-1:0]  ivl_ff, ivl_in;

   // per-slot flags
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [TIMER_SLOTS-1:0] hit_ff, hit_in;
   logic [CW-1:0]          hit_cnt_ff, hit_cnt_in;

   // scan results
   logic [TIME_W-1:0] min_ff, min_in;
   logic              min_any_ff, min_any_in;
   logic [IW-1:0]     free_ff, free_in;
   logic              free_found_ff, free_found_in;
   logic [IW-1:0]     best_ff, best_in;
   logic [TIME_W-1:0] best_dl_ff, best_dl_in;
   logic              best_any_ff, best_any_in;
   logic [TIME_W-1:0] tmp_ff, tmp_in;

   // staged result word
   kind_type          res_kind_ff, res_kind_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic              res_chg_ff, res_chg_in;
   logic              res_arm_ff, res_arm_in;
   logic [TIME_W-1:0] res_dly_ff, res_dly_in;
   logic              res_last_ff, res_last_in;

   // output register
   logic              rsp_vld_ff, rsp_vld_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_chg_ff, rsp_chg_in;
   logic              rsp_arm_ff, rsp_arm_in;
   logic [TIME_W-1:0] rsp_dly_ff, rsp_dly_in;
   logic              rsp_last_ff, rsp_last_in;

   // configuration
   logic [ARM_W-1:0]  min_arm_ff, min_arm_in;

   // deadline and interval memories
   logic [TIME_W-1:0] dl_mem [TIMER_SLOTS];
   logic [IVL_W-1:0]  iv_mem [TIMER_SLOTS];
   logic [TIME_W-1:0] dl_rd_ff;
   logic [IVL_W-1:0]  iv_rd_ff;
   logic              dl_we;
   logic [IW-1:0]     dl_wa;
   logic [TIME_W-1:0] dl_wd;
   logic              iv_we;

   // shared alu
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   logic scanning;
   logic scan_done;
   logic out_free;
   logic changed;

   dtq_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign scanning  = (state_ff == ST_MIN_SCAN) || (state_ff == ST_HIT_SCAN) ||
                      (state_ff == ST_BEST_SCAN);
   // last slot has been evaluated
   assign scan_done = (cnt_ff == SLOT_COUNT) && !ev_vld_ff;
   // output register can take a word this cycle
   assign out_free  = !rsp_vld_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid            = rsp_vld_ff;
   assign rsp_chan.result_kind      = rsp_kind_ff;
   assign rsp_chan.timer_slot       = rsp_slot_ff;
   assign rsp_chan.earliest_changed = rsp_chg_ff;
   assign rsp_chan.arm_valid        = rsp_arm_ff;
   assign rsp_chan.arm_delay_us     = rsp_dly_ff;
   assign rsp_chan.last_result      = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      op_tick_in    = op_tick_ff;
      cnt_in        = cnt_ff;
      ev_vld_in     = 1'b0;
      ev_slot_in    = cnt_ff[IW-1:0];
      now_in        = now_ff;
      when_in       = when_ff;
      ivl_in        = ivl_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      hit_cnt_in    = hit_cnt_ff;
      min_in        = min_ff;
      min_any_in    = min_any_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      best_in       = best_ff;
      best_dl_in    = best_dl_ff;
      best_any_in   = best_any_ff;
      tmp_in        = tmp_ff;
      res_kind_in   = res_kind_ff;
      res_slot_in   = res_slot_ff;
      res_chg_in    = res_chg_ff;
      res_arm_in    = res_arm_ff;
      res_dly_in    = res_dly_ff;
      res_last_in   = res_last_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_chg_in    = rsp_chg_ff;
      rsp_arm_in    = rsp_arm_ff;
      rsp_dly_in    = rsp_dly_ff;
      rsp_last_in   = rsp_last_ff;
      min_arm_in    = csr_wr_en ? csr_wr_data : min_arm_ff;
      dl_we         = 1'b0;
      dl_wa         = free_ff;
      dl_wd         = when_ff;
      iv_we         = 1'b0;
      changed       = 1'b0;
      alu_req.op    = ALU_LT;
      alu_req.a     = dl_rd_ff;
      alu_req.b     = min_ff;

      // slot counter walks the read port while a scan runs
      if (scanning && (cnt_ff < SLOT_COUNT)) begin
         cnt_in    = cnt_ff + CW'(1);
         ev_vld_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               now_in        = req_chan.now_time;
               when_in       = req_chan.expiry_time;
               ivl_in        = req_chan.interval_us;
               op_tick_in    = (req_chan.req_type == REQ_TICK);
               min_any_in    = 1'b0;
               free_found_in = 1'b0;
               hit_cnt_in    = '0;
               state_in      = (req_chan.req_type == REQ_TICK) ? ST_HIT_SCAN
                                                               : ST_MIN_SCAN;
            end
         end

         ST_MIN_SCAN: begin
            if (ev_vld_ff) begin
               if (!valid_ff[ev_slot_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_in       = ev_slot_ff;
               end
               if (valid_ff[ev_slot_ff] && (!min_any_ff || alu_rsp.lt)) begin
                  min_in     = dl_rd_ff;
                  min_any_in = 1'b1;
               end
            end
            if (scan_done) begin
               cnt_in = '0;
               if (!op_tick_ff && !free_found_ff) begin
                  res_kind_in = KIND_ADD_FULL;
                  res_slot_in = '0;
                  res_chg_in  = 1'b0;
                  res_arm_in  = 1'b0;
                  res_dly_in  = '0;
                  res_last_in = 1'b1;
                  state_in    = ST_RESULT;
               end else if (!op_tick_ff) begin
                  state_in = ST_ADD_CMP;
               end else if (min_any_ff) begin
                  state_in = ST_ARM_SUB;
               end else begin
                  // nothing left pending after the tick
                  res_arm_in = 1'b0;
                  res_dly_in = '0;
                  state_in   = ST_RESULT;
               end
            end
         end

         ST_ADD_CMP: begin
            alu_req.a = when_ff;
            alu_req.b = min_ff;
            // a tie with the current earliest is no change
            changed   = !min_any_ff || alu_rsp.lt;
            dl_we     = 1'b1;
            iv_we     = 1'b1;
            valid_in[free_ff] = 1'b1;
            res_kind_in = KIND_ADD_OK;
            res_slot_in = SLOT_W'(free_ff);
            res_chg_in  = changed;
            res_last_in = 1'b1;
            if (changed) begin
               min_in   = when_ff;
               state_in = ST_ARM_SUB;
            end else begin
               res_arm_in = 1'b0;
               res_dly_in = '0;
               state_in   = ST_RESULT;
            end
         end

         ST_HIT_SCAN: begin
            alu_req.a = now_ff;
            alu_req.b = dl_rd_ff;
            // expired when the deadline is not after now
            if (ev_vld_ff && valid_ff[ev_slot_ff] && !alu_rsp.lt) begin
               hit_in[ev_slot_ff] = 1'b1;
               hit_cnt_in         = hit_cnt_ff + CW'(1);
            end
            if (scan_done) begin
               cnt_in = '0;
               if (hit_cnt_ff == '0) begin
                  res_kind_in = KIND_TICK_NONE;
                  res_slot_in = '0;
                  res_chg_in  = 1'b0;
                  res_arm_in  = 1'b0;
                  res_dly_in  = '0;
                  res_last_in = 1'b1;
                  state_in    = ST_RESULT;
               end else begin
                  best_any_in = 1'b0;
                  state_in    = ST_BEST_SCAN;
               end
            end
         end

         ST_BEST_SCAN: begin
            alu_req.a = dl_rd_ff;
            alu_req.b = best_dl_ff;
            // strict compare keeps the lower slot on equal deadlines
            if (ev_vld_ff && hit_ff[ev_slot_ff] && (!best_any_ff || alu_rsp.lt)) begin
               best_in     = ev_slot_ff;
               best_dl_in  = dl_rd_ff;
               best_any_in = 1'b1;
            end
            if (scan_done) begin
               cnt_in   = '0;
               state_in = ST_RELOAD;
            end
         end

         ST_RELOAD: begin
            alu_req.op = ALU_ADD;
            alu_req.a  = now_ff;
            alu_req.b  = TIME_W'(iv_rd_ff);
            if (iv_rd_ff != '0) begin
               dl_we = 1'b1;
               dl_wa = best_ff;
               dl_wd = alu_rsp.res;
            end else begin
               valid_in[best_ff] = 1'b0;
            end
            hit_in[best_ff] = 1'b0;
            hit_cnt_in      = hit_cnt_ff - CW'(1);
            res_kind_in     = KIND_EXPIRED;
            res_slot_in     = SLOT_W'(best_ff);
            res_chg_in      = 1'b0;
            if (hit_cnt_ff == CW'(1)) begin
               // final expired timer: find the next deadline first
               res_last_in = 1'b1;
               min_any_in  = 1'b0;
               state_in    = ST_MIN_SCAN;
            end else begin
               res_arm_in  = 1'b0;
               res_dly_in  = '0;
               res_last_in = 1'b0;
               state_in    = ST_RESULT;
            end
         end

         ST_ARM_SUB: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = min_ff;
            alu_req.b  = now_ff;
            tmp_in     = alu_rsp.res;
            state_in   = ST_ARM_CLAMP;
         end

         ST_ARM_CLAMP: begin
            alu_req.a  = tmp_ff;
            alu_req.b  = TIME_W'(min_arm_ff);
            res_arm_in = 1'b1;
            res_dly_in = alu_rsp.lt ? TIME_W'(min_arm_ff) : tmp_ff;
            state_in   = ST_RESULT;
         end

         ST_RESULT: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = res_kind_ff;
               rsp_slot_in = res_slot_ff;
               rsp_chg_in  = res_chg_ff;
               rsp_arm_in  = res_arm_ff;
               rsp_dly_in  = res_dly_ff;
               rsp_last_in = res_last_ff;
               best_any_in = 1'b0;
               state_in    = res_last_ff ? ST_IDLE : ST_BEST_SCAN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         ev_vld_ff   <= 1'b0;
         valid_ff    <= '0;
         hit_ff      <= '0;
         hit_cnt_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
         min_arm_ff  <= MIN_ARM_RESET;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ev_vld_ff   <= ev_vld_in;
         valid_ff    <= valid_in;
         hit_ff      <= hit_in;
         hit_cnt_ff  <= hit_cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
         min_arm_ff  <= min_arm_in;
      end
      op_tick_ff    <= op_tick_in;
      ev_slot_ff    <= ev_slot_in;
      now_ff        <= now_in;
      when_ff       <= when_in;
      ivl_ff        <= ivl_in;
      min_ff        <= min_in;
      min_any_ff    <= min_any_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      best_ff       <= best_in;
      best_dl_ff    <= best_dl_in;
      best_any_ff   <= best_any_in;
      tmp_ff        <= tmp_in;
      res_kind_ff   <= res_kind_in;
      res_slot_ff   <= res_slot_in;
      res_chg_ff    <= res_chg_in;
      res_arm_ff    <= res_arm_in;
      res_dly_ff    <= res_dly_in;
      res_last_ff   <= res_last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_chg_ff    <= rsp_chg_in;
      rsp_arm_ff    <= rsp_arm_in;
      rsp_dly_ff    <= rsp_dly_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // deadline memory: scan read port, one write port
   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_wa] <= dl_wd;
      end
      if (cnt_ff < SLOT_COUNT) begin
         dl_rd_ff <= dl_mem[cnt_ff[IW-1:0]];
      end
   end

   // interval memory: written on add, read at the chosen slot
   always_ff @(posedge clock) begin
      if (iv_we) begin
         iv_mem[free_ff] <= ivl_ff;
      end
      iv_rd_ff <= iv_mem[best_ff];
   end

endmodule

@@ hw/rtl/dtq_checker.sv @@
// ----------------------------------------------------------------------------
// dtq_checker: port-level checks of the deadline timer queue
// bound to the top level, watches the request and response channels
// ----------------------------------------------------------------------------
module dtq_checker import dtq_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        result_kind,
   input logic [SLOT_W-1:0] timer_slot,
   input logic              earliest_changed,
   input logic              arm_valid,
   input logic              last_result
);

   // the sequencer is busy right after it takes a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before taken");

   // adds always give exactly one word
   a_add_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_kind == KIND_ADD_OK || result_kind == KIND_ADD_FULL)
      |-> last_result)
      else $error("add word not marked last");

   a_quiet_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (result_kind == KIND_ADD_FULL || result_kind == KIND_TICK_NONE)
      |-> !arm_valid && !earliest_changed && (timer_slot == '0) && last_result)
      else $error("full or empty word carries data");

   a_changed_arms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && earliest_changed |-> arm_valid && (result_kind == KIND_ADD_OK))
      else $error("earliest change without arming");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .result_kind      (rsp_chan.result_kind),
   .timer_slot       (rsp_chan.timer_slot),
   .earliest_changed (rsp_chan.earliest_changed),
   .arm_valid        (rsp_chan.arm_valid),
   .last_result      (rsp_chan.last_result)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the deadline timer queue
// drives add and tick words with random gaps, predicts every result word in a
// scoreboard class that keeps its own copy of the timer table and the minimum
// arming delay, and compares each accepted result word against the oldest one
// ----------------------------------------------------------------------------
module tb;
   import dtq_pkg::*;

   localparam int N             = TIMER_SLOTS_DEFAULT;
   localparam int STALL_LIMIT   = 2000;      // cycles with no handshake at all
   localparam int SETTLE_CYCLES = 2 * (N + 5);
   localparam int PHASE_WORDS   = 17;
   localparam int PHASES        = 5;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam logic [IVL_W-1:0]  IVL_MAX  = '1;
   localparam logic [ARM_W-1:0]  ARM_MAX  = '1;

   // one result word as seen on the response channel
   typedef struct packed {
      kind_type          kind;
      logic [SLOT_W-1:0] slot;
      logic              changed;
      logic              armed;
      logic [TIME_W-1:0] delay;
      logic              closing;
   } timer_word_type;

   // ---------------------------------------------------------------------------
   // scoreboard: shadow timer table and the queue of result words still due
   // ---------------------------------------------------------------------------
   class timer_scoreboard_type;
      bit                busy   [N];
      logic [TIME_W-1:0] due    [N];
      logic [IVL_W-1:0]  period [N];
      logic [ARM_W-1:0]  min_arm;
      timer_word_type    due_words[$];
      int                mismatches;

      function new();
         foreach (busy[i]) busy[i] = 1'b0;
         min_arm    = MIN_ARM_RESET;
         mismatches = 0;
      endfunction

      function void set_min_arm(logic [ARM_W-1:0] value);
         min_arm = value;
      endfunction

      function int pending();
         return due_words.size();
      endfunction

      // distance to a deadline, never below the configured floor
      function logic [TIME_W-1:0] arm_after(logic [TIME_W-1:0] deadline,
                                            logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] d;
         d = (deadline > now) ? deadline - now : '0;
         if (d < TIME_W'(min_arm)) d = TIME_W'(min_arm);
         return d;
      endfunction

      function bit earliest_due(output logic [TIME_W-1:0] soonest);
         bit any;
         any     = 1'b0;
         soonest = '0;
         for (int i = 0; i < N; i++)
            if (busy[i] && (!any || due[i] < soonest)) begin
               soonest = due[i];
               any     = 1'b1;
            end
         return any;
      endfunction

      function void note_request(logic op, logic [TIME_W-1:0] now,
                                 logic [TIME_W-1:0] expiry, logic [IVL_W-1:0] ivl);
         timer_word_type    w;
         int                free_idx;
         int                count;
         int                best;
         bit                any;
         bit                hit [N];
         logic [TIME_W-1:0] soonest;
         logic [TIME_W:0]   sum;

         w = '0;
         if (op == REQ_ADD) begin
            free_idx = -1;
            for (int i = 0; i < N; i++)
               if (!busy[i] && free_idx < 0) free_idx = i;
            w.closing = 1'b1;
            if (free_idx < 0) begin
               w.kind = KIND_ADD_FULL;
            end else begin
               any       = earliest_due(soonest);
               w.kind    = KIND_ADD_OK;
               w.slot    = SLOT_W'(free_idx);
               w.changed = !any || expiry < soonest;
               w.armed   = w.changed;
               if (w.changed) w.delay = arm_after(expiry, now);
               busy[free_idx]   = 1'b1;
               due[free_idx]    = expiry;
               period[free_idx] = ivl;
            end
            due_words.push_back(w);
            return;
         end

         // expiry set is fixed before any reload
         count = 0;
         for (int i = 0; i < N; i++) begin
            hit[i] = busy[i] && due[i] <= now;
            if (hit[i]) count++;
         end
         if (count == 0) begin
            w.kind    = KIND_TICK_NONE;
            w.closing = 1'b1;
            due_words.push_back(w);
            return;
         end
         for (int k = 0; k < count; k++) begin
            best = -1;
            for (int i = 0; i < N; i++)
               if (hit[i] && (best < 0 || due[i] < due[best])) best = i;
            hit[best] = 1'b0;
            if (period[best] != '0) begin
               sum       = {1'b0, now} + (TIME_W+1)'(period[best]);
               due[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end else begin
               busy[best] = 1'b0;
            end
            w      = '0;
            w.kind = KIND_EXPIRED;
            w.slot = SLOT_W'(best);
            if (k == count - 1) begin
               any       = earliest_due(soonest);
               w.armed   = any;
               w.closing = 1'b1;
               if (any) w.delay = arm_after(soonest, now);
            end
            due_words.push_back(w);
         end
      endfunction

      function void report(string what, timer_word_type want, timer_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t %s: expected kind=%0d slot=%0d chg=%0b arm=%0b delay=%0d last=%0b",
                     $time, what, want.kind, want.slot, want.changed, want.armed,
                     want.delay, want.closing,
                     "\n   got kind=%0d slot=%0d chg=%0b arm=%0b delay=%0d last=%0b",
                     got.kind, got.slot, got.changed, got.armed, got.delay, got.closing);
      endfunction

      function void check_result(timer_word_type got);
         timer_word_type want;
         if (due_words.size() == 0) begin
            report("result word with nothing due", '0, got);
            return;
         end
         want = due_words.pop_front();
         if (got !== want) report("result word mismatch", want, got);
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ---------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [ARM_W-1:0] csr_wr_data;

   dtq_req_if req_chan ();
   dtq_rsp_if rsp_chan ();

   timer_scoreboard_type board;
   timer_word_type       rsp_word;
   int                rsp_hold;     // cycles left before the sink takes a word again
   int                idle_run;     // watchdog count
   bit                req_calm;     // no gaps between request words
   bit                rsp_calm;     // no stalls on the result side
   logic [TIME_W-1:0] sim_now;      // running time base for well-formed traffic
   logic [TIME_W-1:0] last_expiry;  // reused now and then to hit earliest ties

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   deadline_timer_queue #(.TIMER_SLOTS(N)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // ---------------------------------------------------------------------------
   // result sink: take a word, then hold ready low for a random stretch
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_word.kind    = kind_type'(rsp_chan.result_kind);
            rsp_word.slot    = rsp_chan.timer_slot;
            rsp_word.changed = rsp_chan.earliest_changed;
            rsp_word.armed   = rsp_chan.arm_valid;
            rsp_word.delay   = rsp_chan.arm_delay_us;
            rsp_word.closing = rsp_chan.last_result;
            board.check_result(rsp_word);
            rsp_hold = rsp_calm ? 0 : int'($urandom_range(0, 9));
         end
         if (rsp_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog: too long without any handshake means the block is stuck
   always @(posedge clock) begin
      if (reset) begin
         idle_run = 0;
      end else begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_run = 0;
         else
            idle_run++;
         if (idle_run >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------

   // present one word after a random gap and wait for it to be taken;
   // valid stays high on return so a zero gap keeps words back to back
   task automatic send_word(logic op, logic [TIME_W-1:0] now,
                            logic [TIME_W-1:0] expiry, logic [IVL_W-1:0] ivl);
      int gap;
      gap = req_calm ? 0 : int'($urandom_range(0, 9));
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= op;
      req_chan.now_time    <= now;
      req_chan.expiry_time <= expiry;
      req_chan.interval_us <= ivl;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(op, now, expiry, ivl);
   endtask

   // drop valid and wait until every result is in and the block is idle again
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (board.pending() != 0 || !req_chan.ready) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_arm(logic [ARM_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_min_arm(value);
   endtask

   // hand-picked words: edge values and each corner of the timer table
   task automatic directed_words();
      send_word(REQ_TICK, '0, '0, '0);             // tick on an empty table
      send_word(REQ_ADD, 1000, 5000, '0);          // first timer, always earliest
      send_word(REQ_ADD, 1000, 5000, 300);         // same deadline, no change
      send_word(REQ_ADD, 1000, 1050, '0);          // short delay raised to the floor
      send_word(REQ_ADD, 2000, 1500, IVL_MAX);     // deadline already past
      send_word(REQ_ADD, '0, TIME_MAX, '0);        // latest possible deadline
      send_word(REQ_TICK, 5000, '0, '0);           // four expire, tie on slot order
      send_word(REQ_TICK, TIME_MAX, TIME_MAX, IVL_MAX); // reloads saturate
      send_word(REQ_TICK, '0, '0, '0);             // nothing due
      // fill the table, the first one with deadline zero
      for (int i = 0; i < N - 2; i++)
         send_word(REQ_ADD, '0, TIME_W'(i * 7), '0);
      send_word(REQ_ADD, 100, 200, 5);             // table full
      send_word(REQ_TICK, 1000, '0, '0);           // frees the one-shot timers
   endtask

   // mostly well-formed traffic around a moving time base, some noise
   task automatic random_word();
      int                pick;
      logic [TIME_W-1:0] expiry;
      logic [IVL_W-1:0]  ivl;
      logic [TIME_W-1:0] wild;
      pick = int'($urandom_range(0, 99));
      wild = TIME_W'({$urandom, $urandom});
      if (pick < 8) begin
         // noise over the whole field ranges; a wild tick also moves the time base
         if ($urandom_range(0, 1)) begin
            sim_now = wild;
            send_word(REQ_TICK, wild, TIME_W'({$urandom, $urandom}),
                      IVL_W'({$urandom, $urandom}));
         end else begin
            send_word(REQ_ADD, wild, TIME_W'({$urandom, $urandom}),
                      IVL_W'({$urandom, $urandom}));
         end
      end else if (pick < 52) begin
         case ($urandom_range(0, 9))
            0:       expiry = last_expiry;
            1:       expiry = sim_now - TIME_W'($urandom_range(0, 500));
            default: expiry = sim_now + TIME_W'($urandom_range(0, 3000));
         endcase
         case ($urandom_range(0, 9))
            0:       ivl = IVL_W'({$urandom, $urandom});
            1, 2:    ivl = IVL_W'($urandom_range(1, 4000));
            default: ivl = '0;
         endcase
         last_expiry = expiry;
         send_word(REQ_ADD, sim_now, expiry, ivl);
      end else begin
         sim_now = sim_now + TIME_W'($urandom_range(0, 2500));
         send_word(REQ_TICK, sim_now, wild, IVL_W'({$urandom, $urandom}));
      end
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------
   initial begin
      logic [ARM_W-1:0] floor_value [PHASES];

      board       = new();
      req_calm    = 1'b0;
      rsp_calm    = 1'b0;
      sim_now     = 10000;
      last_expiry = 10000;

      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_wr_data          <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.req_type    <= REQ_ADD;
      req_chan.now_time    <= '0;
      req_chan.expiry_time <= '0;
      req_chan.interval_us <= '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part runs with the reset floor
      directed_words();
      settle();

      // floor settings per phase, extremes first
      floor_value[0] = '0;
      floor_value[1] = ARM_MAX;
      floor_value[2] = ARM_W'($urandom);
      floor_value[3] = ARM_W'($urandom_range(0, 5000));
      floor_value[4] = MIN_ARM_RESET;

      for (int ph = 0; ph < PHASES; ph++) begin
         // phase 1 runs with no idling at all, 2 and 3 calm one side each
         req_calm = (ph == 1 || ph == 2);
         rsp_calm = (ph == 1 || ph == 3);
         write_min_arm(floor_value[ph]);
         repeat (PHASE_WORDS) random_word();
         settle();
      end

      if (board.mismatches == 0 && board.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
